FILE: rtl/cobs_enc_pkg.sv
// Shared types, constants and helpers (block close, write append) for the COBS frame encoder.
package cobs_enc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 1024;
  localparam int unsigned CapW            = 11;
  localparam int unsigned AddrW           = 10;

  localparam logic [7:0]      FULL_BLOCK  = 8'hFE;
  localparam logic [CapW-1:0] CAP_RESET   = CapW'(1024);
  localparam logic [CapW-1:0] CAP_MAX     = CapW'(MAX_FRAME_BYTES);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2
  } cobs_op_e;

  typedef enum logic [1:0] {
    MODE_RUNNING = 2'd0,
    MODE_DONE    = 2'd1,
    MODE_FAIL    = 2'd2
  } cobs_mode_e;

  typedef struct packed {
    logic [CapW-1:0] bs;   // block start
    logic [7:0]      bl;   // block length
    cobs_mode_e      md;
  } enc_state_t;

  // Up to two memory writes plus the fields common to all results of an item.
  typedef struct packed {
    logic [1:0]       cnt;
    logic [AddrW-1:0] addr0;
    logic [7:0]       data0;
    logic [AddrW-1:0] addr1;
    logic [7:0]       data1;
    logic             acc;
    cobs_mode_e       md;
    logic [CapW-1:0]  flen;
  } res_pair_t;

  typedef struct packed {
    enc_state_t      st;
    logic            ok;
    logic [AddrW-1:0] addr;
    logic [7:0]      data;
  } close_t;

  // Close the open block: code byte at its start, then open a new block; fail if the block end reaches the capacity.
  function automatic close_t close_blk(input enc_state_t st, input logic [CapW-1:0] cap);
    close_t          r;
    logic [CapW-1:0] top;
    r      = '0;
    r.st   = st;
    top    = st.bs + CapW'(st.bl);
    if (st.md != MODE_RUNNING) begin
      r.ok = 1'b0;
    end else if (top >= cap) begin
      r.st.md = MODE_FAIL;
    end else begin
      r.ok    = 1'b1;
      r.addr  = st.bs[AddrW-1:0];
      r.data  = st.bl + 8'd1;
      r.st.bs = top + CapW'(1);
      r.st.bl = '0;
    end
    return r;
  endfunction

  // Append one write to the result pair.
  function automatic res_pair_t push_wr(input res_pair_t p, input logic [AddrW-1:0] a,
                                        input logic [7:0] d);
    res_pair_t r;
    r = p;
    if (p.cnt == 2'd0) begin
      r.addr0 = a;
      r.data0 = d;
    end else begin
      r.addr1 = a;
      r.data1 = d;
    end
    r.cnt = p.cnt + 2'd1;
    return r;
  endfunction

endpackage

FILE: rtl/cobs_enc_step.sv
// Encoder state registers and the single-pass update for one item.
module cobs_enc_step
  import cobs_enc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [CapW-1:0] cap_i,
  input  logic [1:0]      op_i,
  input  logic [7:0]      byte_i,
  output res_pair_t       pair_o
);

  enc_state_t      state_q, state_d;
  enc_state_t      st;
  res_pair_t       p;
  close_t          c1, c2;
  logic            ok;
  logic [CapW-1:0] idx;

  always_comb begin
    st  = state_q;
    p   = '0;
    c1  = '0;
    c2  = '0;
    ok  = 1'b0;
    idx = st.bs + CapW'(st.bl) + CapW'(1);
    unique case (op_i)
      OP_START: begin
        st.md = MODE_RUNNING;
        if (cap_i == '0) begin
          st.md = MODE_FAIL;
        end else begin
          st.bs = '0;
          st.bl = '0;
        end
      end
      OP_DATA: begin
        if (st.md == MODE_RUNNING) begin
          ok = 1'b1;
          // full block: close with code 0xFF before placing the byte
          if (st.bl >= FULL_BLOCK) begin
            c1 = close_blk(st, cap_i);
            st = c1.st;
            ok = c1.ok;
            if (c1.ok) p = push_wr(p, c1.addr, c1.data);
          end
          if (ok) begin
            if (byte_i == 8'd0) begin
              c2 = close_blk(st, cap_i);
              st = c2.st;
              ok = c2.ok;
              if (c2.ok) p = push_wr(p, c2.addr, c2.data);
            end else begin
              idx = st.bs + CapW'(st.bl) + CapW'(1);
              if (idx >= cap_i) begin
                st.md = MODE_FAIL;
                ok    = 1'b0;
              end else begin
                p     = push_wr(p, idx[AddrW-1:0], byte_i);
                st.bl = st.bl + 8'd1;
              end
            end
          end
        end
      end
      OP_END: begin
        if (st.md == MODE_RUNNING) begin
          c1 = close_blk(st, cap_i);
          st = c1.st;
          if (c1.ok) begin
            p     = push_wr(p, c1.addr, c1.data);
            st.md = MODE_DONE;
            idx   = st.bs + CapW'(st.bl);
            if (idx >= cap_i) begin
              st.md = MODE_FAIL;
            end else begin
              p = push_wr(p, idx[AddrW-1:0], 8'd0);
            end
          end
        end
      end
      default: begin
        st = state_q;
      end
    endcase
    p.acc   = ok;
    p.md    = st.md;
    p.flen  = st.bs + CapW'(st.bl) + CapW'(1);
    state_d = st;
  end

  assign pair_o = p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{bs: '0, bl: '0, md: MODE_RUNNING};
    end else if (load_i) begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/cobs_enc_outq.sv
// Result register: holds one item's results and hands them out one at a time.
module cobs_enc_outq
  import cobs_enc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  res_pair_t        pair_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             write_enable_o,
  output logic [AddrW-1:0] write_address_o,
  output logic [7:0]       write_data_o,
  output logic             accepted_o,
  output logic [1:0]       mode_o,
  output logic [CapW-1:0]  frame_length_o,
  output logic             last_o
);

  res_pair_t res_q;
  logic      valid_q, valid_d;
  logic      sel_q, sel_d;
  logic      pop, pop_last;

  assign out_valid_o     = valid_q;
  assign last_o          = sel_q || (res_q.cnt < 2'd2);
  assign write_enable_o  = sel_q || (res_q.cnt != 2'd0);
  assign write_address_o = sel_q ? res_q.addr1 :
                           ((res_q.cnt != 2'd0) ? res_q.addr0 : '0);
  assign write_data_o    = sel_q ? res_q.data1 :
                           ((res_q.cnt != 2'd0) ? res_q.data0 : '0);
  assign accepted_o      = res_q.acc;
  assign mode_o          = res_q.md;
  assign frame_length_o  = res_q.flen;

  assign pop      = valid_q && !out_stall_i;
  assign pop_last = pop && last_o;
  assign free_o   = !valid_q || pop_last;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load_i) begin
      valid_d = 1'b1;
      sel_d   = 1'b0;
    end else if (pop_last) begin
      valid_d = 1'b0;
      sel_d   = 1'b0;
    end else if (pop) begin
      sel_d = 1'b1;   // advance to the second write
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= pair_i;
  end

endmodule

FILE: rtl/cobs_frame_encoder_core.sv
// Top level of the COBS frame encoder: input register, capacity register, glue.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   opcode_i, data_byte_i
//   out      output     out_valid_o / out_stall_i write_*_o, accepted_o, mode_o,
//                                                 frame_length_o, last_o
//   cfg      input      cfg_we_i                  cfg_wdata_i (buffer capacity)
//
// An item is registered on entry into the input register, then encoded into the result
// register once that register is free.
// Items giving one result flow at one per cycle while the output does not stall; an item
// with two writes holds the result register until both are taken, the output port being the limit.
// Reset clears the encoder state to running with an empty frame, capacity 1024.
// An output stall holds the result register and backs up into the input register.
module cobs_frame_encoder_core
  import cobs_enc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CapW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             write_enable_o,
  output logic [AddrW-1:0] write_address_o,
  output logic [7:0]       write_data_o,
  output logic             accepted_o,
  output logic [1:0]       mode_o,
  output logic [CapW-1:0]  frame_length_o,
  output logic             last_o
);

  logic [CapW-1:0] cap_q, cap_eff;
  logic            in_valid_q, in_valid_d;
  logic [1:0]      op_q;
  logic [7:0]      byte_q;
  logic            accept, load, free;
  res_pair_t       pair;

  assign cap_eff    = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;
  assign load       = in_valid_q && free;
  assign in_stall_o = in_valid_q && !load;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept)    in_valid_d = 1'b1;
    else if (load) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cap_q      <= CAP_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      byte_q <= data_byte_i;
    end
  end

  cobs_enc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .cap_i  (cap_eff),
    .op_i   (op_q),
    .byte_i (byte_q),
    .pair_o (pair)
  );

  cobs_enc_outq u_outq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .pair_i          (pair),
    .free_o          (free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_enable_o  (write_enable_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .accepted_o      (accepted_o),
    .mode_o          (mode_o),
    .frame_length_o  (frame_length_o),
    .last_o          (last_o)
  );

`ifndef SYNTHESIS
  // the first of two results is always a memory write
  a_first_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> write_enable_o)
    else $error("first of two results carries no write");

  // a second result always follows a non-final one
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=> out_valid_o)
    else $error("second result of an item missing");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && in_valid_q)
    else $error("input stalled with empty result register");
`endif

endmodule

FILE: verif/cobs_frame_encoder_core_tb.sv
// Self-checking testbench for the COBS frame encoder core.
`timescale 1ns / 1ps

module cobs_frame_encoder_core_tb;
  import cobs_enc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD  = 300;
  localparam int CYCLE_CAP  = 600000;
  localparam int SETTLE     = 4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } stim_item_t;

  typedef struct packed {
    logic [CapW-1:0] addr;
    logic [7:0]      data;
  } mem_write_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
    logic             acc;
    cobs_mode_e       md;
    logic [CapW-1:0]  flen;
    logic             last;
  } enc_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CapW-1:0]  cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [1:0]       opcode_i    = OP_START;
  logic [7:0]       data_byte_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             write_enable_o;
  logic [AddrW-1:0] write_address_o;
  logic [7:0]       write_data_o;
  logic             accepted_o;
  logic [1:0]       mode_o;
  logic [CapW-1:0]  frame_length_o;
  logic             last_o;

  cobs_frame_encoder_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .accepted_o     (accepted_o),
    .mode_o         (mode_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

  // Encoder state mirror and capacity register mirror.
  logic [CapW-1:0] enc_start    = '0;
  logic [7:0]      enc_len      = '0;
  cobs_mode_e      enc_mode     = MODE_RUNNING;
  logic [CapW-1:0] enc_capacity = CAP_RESET;

  stim_item_t  pending_items[$];
  mem_write_t  item_writes[$];
  enc_result_t encoded_results[$];

  int  queued_cnt   = 0;
  int  accepted_cnt = 0;
  int  results_seen = 0;
  int  err_cnt      = 0;
  int  frames_done  = 0;
  int  fail_events  = 0;
  int  full_closes  = 0;
  int  cycle_cnt    = 0;
  bit  in_taken     = 1'b0;
  bit  in_idle_en   = 1'b0;
  bit  out_idle_en  = 1'b0;
  bit  stall_hold_req = 1'b0;
  int  send_gap     = 0;
  int  stall_left   = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               encoded_results.size());
      $display("cobs_frame_encoder_core verification failed");
      $finish;
    end
  end

  function automatic int pick_gap(input bit en);
    int r;
    r = $urandom_range(0, 99);
    if (!en || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Write the open block's code byte and open a new block.
  function automatic bit close_open_block(input int unsigned cap);
    int unsigned top;
    top = enc_start + enc_len;
    if (enc_mode != MODE_RUNNING) return 1'b0;
    if (top >= cap) begin
      enc_mode = MODE_FAIL;
      fail_events++;
      return 1'b0;
    end
    item_writes.push_back('{enc_start, enc_len + 8'd1});
    if (enc_len == FULL_BLOCK) full_closes++;
    enc_start = CapW'(top + 1);
    enc_len   = '0;
    return 1'b1;
  endfunction

  function automatic void encode_item(input logic [1:0] op, input logic [7:0] b);
    int unsigned cap, slot, n;
    int k;
    bit ok;
    enc_result_t r;
    cap = (enc_capacity > CAP_MAX) ? CAP_MAX : enc_capacity;
    item_writes.delete();
    ok = 1'b0;
    case (op)
      OP_START: begin
        enc_mode = MODE_RUNNING;
        if (cap == 0) begin
          enc_mode = MODE_FAIL;
          fail_events++;
        end else begin
          enc_start = '0;
          enc_len   = '0;
        end
      end
      OP_DATA: if (enc_mode == MODE_RUNNING) begin
        ok = 1'b1;
        if (enc_len >= FULL_BLOCK) ok = close_open_block(cap);
        if (ok && b == 8'h00) begin
          ok = close_open_block(cap);
        end else if (ok) begin
          slot = enc_start + enc_len + 1;
          if (slot >= cap) begin
            enc_mode = MODE_FAIL;
            fail_events++;
            ok = 1'b0;
          end else begin
            item_writes.push_back('{CapW'(slot), b});
            enc_len++;
          end
        end
      end
      OP_END: if (enc_mode == MODE_RUNNING && close_open_block(cap)) begin
        if (enc_start >= cap) begin
          enc_mode = MODE_FAIL;
          fail_events++;
        end else begin
          enc_mode = MODE_DONE;
          frames_done++;
          item_writes.push_back('{enc_start, 8'h00});
        end
      end
      default: ;
    endcase
    n = (item_writes.size() == 0) ? 1 : item_writes.size();
    for (k = 0; k < n; k++) begin
      r      = '0;
      r.acc  = ok;
      r.md   = enc_mode;
      r.flen = CapW'(enc_start + enc_len + 1);
      r.last = (k == n - 1);
      if (k < item_writes.size()) begin
        r.we   = 1'b1;
        r.addr = item_writes[k].addr[AddrW-1:0];
        r.data = item_writes[k].data;
      end
      encoded_results.push_back(r);
    end
  endfunction

  // Check results against the oldest expectation, then record accepted items.
  always @(posedge clk_i) begin : mon
    enc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (encoded_results.size() == 0) begin
        $error("unexpected result: addr %0d data 0x%02h", write_address_o, write_data_o);
        err_cnt++;
      end else begin
        want = encoded_results.pop_front();
        if (write_enable_o !== want.we) begin
          $error("write_enable: expected %0d, got %0d", want.we, write_enable_o);
          err_cnt++;
        end
        if (write_address_o !== want.addr) begin
          $error("write_address: expected %0d, got %0d", want.addr, write_address_o);
          err_cnt++;
        end
        if (write_data_o !== want.data) begin
          $error("write_data: expected 0x%02h, got 0x%02h", want.data, write_data_o);
          err_cnt++;
        end
        if (accepted_o !== want.acc) begin
          $error("accepted: expected %0d, got %0d", want.acc, accepted_o);
          err_cnt++;
        end
        if (mode_o !== want.md) begin
          $error("mode: expected %0d, got %0d", want.md, mode_o);
          err_cnt++;
        end
        if (frame_length_o !== want.flen) begin
          $error("frame_length: expected %0d, got %0d", want.flen, frame_length_o);
          err_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          err_cnt++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      encode_item(opcode_i, data_byte_i);
      in_taken = 1'b1;
      accepted_cnt++;
    end
  end

  // Hold the item until taken, then insert a gap or advance to the next one.
  always @(negedge clk_i) begin : drv
    stim_item_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        opcode_i    <= nxt.op;
        data_byte_i <= nxt.b;
        in_valid_i  <= 1'b1;
        send_gap = pick_gap(in_idle_en);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_hold_req) begin
      stall_left = LONG_HOLD;
      stall_hold_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap(out_idle_en);
    end
  end

  task automatic queue_item(input logic [1:0] op, input logic [7:0] b);
    pending_items.push_back('{op, b});
    queued_cnt++;
  endtask

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) return 8'h00;
    if (r < 24) return 8'hFF;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic queue_frame(input int len, input bit with_end);
    int j;
    queue_item(OP_START, 8'($urandom));
    for (j = 0; j < len; j++) queue_item(OP_DATA, random_byte());
    if (with_end) queue_item(OP_END, 8'($urandom));
  endtask

  // A run of nonzero bytes near a block's size; a run of 254 or more fills a block.
  task automatic queue_long_frame(input int run, input bit zero_after);
    int j;
    queue_item(OP_START, 8'($urandom));
    for (j = 0; j < run; j++) queue_item(OP_DATA, 8'($urandom_range(1, 255)));
    if (zero_after) queue_item(OP_DATA, 8'h00);
    repeat ($urandom_range(0, 3)) queue_item(OP_DATA, random_byte());
    queue_item(OP_END, 8'($urandom));
  endtask

  task automatic fill_random(input int quota, input int forced, input bit allow_long);
    int base, pick;
    base = queued_cnt;
    while (queued_cnt - base < quota) begin
      pick = $urandom_range(0, 99);
      if (forced == 2) begin
        queue_long_frame(254, 1'b1);
        forced--;
      end else if (forced == 1) begin
        queue_long_frame(255, 1'b0);
        forced--;
      end else if (allow_long && pick < 4) begin
        queue_long_frame($urandom_range(252, 257), 1'($urandom_range(0, 1)));
      end else if (pick < 72) begin
        queue_frame($urandom_range(0, 24), $urandom_range(0, 99) < 88);
      end else if (pick < 79) begin
        // stray bytes and a doubled end
        repeat ($urandom_range(1, 4)) queue_item(OP_DATA, random_byte());
        queue_item(OP_END, 8'($urandom));
        queue_item(OP_END, 8'($urandom));
      end else if (pick < 86) begin
        // restart in mid frame
        queue_frame($urandom_range(1, 8), 1'b0);
        queue_frame($urandom_range(0, 8), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || encoded_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Wait for idle, write the capacity, pick new idling for both sides.
  task automatic next_phase(input logic [CapW-1:0] cap);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    enc_capacity = cap;
    in_idle_en  = $urandom_range(0, 3) != 0;
    out_idle_en = $urandom_range(0, 3) != 0;
  endtask

  initial begin
    int base;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    in_idle_en  = $urandom_range(0, 1);
    out_idle_en = $urandom_range(0, 1);

    // reset capacity: byte extremes, zeros, ignored items after completion
    queue_item(OP_START, 8'hFF);
    queue_item(OP_DATA, 8'h00);
    queue_item(OP_DATA, 8'hFF);
    queue_item(OP_DATA, 8'h01);
    queue_item(OP_DATA, 8'h80);
    queue_item(OP_DATA, 8'h7F);
    queue_item(OP_DATA, 8'h00);
    queue_item(OP_END, 8'h00);
    queue_item(OP_DATA, 8'h12);
    queue_item(OP_END, 8'h55);
    queue_item(OP_UNUSED, 8'hAA);
    queue_item(OP_START, 8'h00);
    queue_item(OP_END, 8'hFF);

    // zero capacity fails at start
    next_phase(CapW'(0));
    queue_item(OP_START, 8'h00);
    queue_item(OP_DATA, 8'h33);
    queue_item(OP_END, 8'h00);
    queue_item(OP_START, 8'h00);

    // one byte of memory: code fits, delimiter or data overflows
    next_phase(CapW'(1));
    queue_item(OP_START, 8'h00);
    queue_item(OP_END, 8'h00);
    queue_item(OP_START, 8'h00);
    queue_item(OP_DATA, 8'h44);

    // largest register value, clamped to the frame limit
    next_phase(CapW'(2047));
    queue_item(OP_START, 8'h00);
    queue_item(OP_DATA, 8'h00);
    queue_item(OP_END, 8'h00);

    // full blocks; the receiver holds off long while the sender keeps going
    next_phase(CAP_RESET);
    in_idle_en = 1'b0;
    base = accepted_cnt;
    fill_random(450, 2, 1'b0);
    while (accepted_cnt < base + 60) @(posedge clk_i);
    stall_hold_req = 1'b1;

    next_phase(CapW'(2047));
    fill_random(100, 0, 1'b0);
    next_phase(CapW'($urandom_range(1, 40)));
    fill_random(100, 0, 1'b0);
    next_phase(CapW'($urandom_range(41, 1023)));
    fill_random(80, 0, 1'b1);
    next_phase(CapW'(0));
    fill_random(20, 0, 1'b0);
    next_phase(CapW'($urandom_range(1, 40)));
    fill_random(40, 0, 1'b0);
    drain();
    repeat (8) @(negedge clk_i);

    $display("%0d items accepted, %0d results checked, %0d frames completed",
             accepted_cnt, results_seen, frames_done);
    $display("%0d overflow or zero-capacity failures, %0d full blocks closed",
             fail_events, full_closes);
    if (err_cnt == 0 && encoded_results.size() == 0) begin
      $display("cobs_frame_encoder_core verification clean");
    end else begin
      $display("cobs_frame_encoder_core verification failed");
    end
    $finish;
  end

endmodule
